// File: rtl/psr_pkg.sv
`timescale 1ns / 1ps

package psr_pkg;

   // Field widths fixed by the item format
   localparam int MODE_W  = 2;
   localparam int SIG_W   = 8;
   localparam int PRIO_W  = 6;
   localparam int STAT_W  = 2;
   localparam int LIMIT_W = 9;

   // Default sizing
   localparam int DEF_MAX_ACTIVE        = 32;
   localparam int DEF_MAX_SIGNALS       = 256;
   localparam int DEF_FIRST_USER_SIGNAL = 4;

   // Command queue depth between front and back
   localparam int Q_DEPTH = 2;

   // Register reset value
   localparam logic [LIMIT_W-1:0] MAX_SIGNAL_RESET = 9'd256;

   // Request modes
   localparam logic [MODE_W-1:0] MODE_PUBLISH   = 2'd0;
   localparam logic [MODE_W-1:0] MODE_SUBSCRIBE = 2'd1;
   localparam logic [MODE_W-1:0] MODE_UNSUB     = 2'd2;
   localparam logic [MODE_W-1:0] MODE_UNSUB_ALL = 2'd3;

   // Response status codes
   localparam logic [STAT_W-1:0] ST_OK      = 2'd0;
   localparam logic [STAT_W-1:0] ST_NONE    = 2'd1;
   localparam logic [STAT_W-1:0] ST_BADSIG  = 2'd2;
   localparam logic [STAT_W-1:0] ST_BADPRIO = 2'd3;

   // Work the back end has to do for one item
   typedef enum logic [2:0] {
      OP_REPLY,
      OP_PUBLISH,
      OP_SET,
      OP_CLEAR,
      OP_CLEAR_ALL
   } op_type;

   typedef struct packed {
      op_type              op;
      logic [STAT_W-1:0]   status;
      logic [SIG_W-1:0]    signal;
      logic [PRIO_W-1:0]   prio;
   } cmd_type;

endpackage

// File: rtl/psr_front.sv
`timescale 1ns / 1ps

module psr_front
   import psr_pkg::*;
#(
   parameter int MAX_ACTIVE        = DEF_MAX_ACTIVE,
   parameter int FIRST_USER_SIGNAL = DEF_FIRST_USER_SIGNAL
) (
   input  logic [MODE_W-1:0]  mode,
   input  logic [SIG_W-1:0]   signal,
   input  logic [PRIO_W-1:0]  priority_req,
   input  logic [LIMIT_W-1:0] limit,
   output cmd_type            cmd
);

   localparam logic [PRIO_W:0] MAX_PRIO  = (PRIO_W + 1)'(MAX_ACTIVE);
   localparam logic [SIG_W-1:0] FIRST_SIG = SIG_W'(FIRST_USER_SIGNAL);

   logic sig_over;
   logic prio_bad;

   assign sig_over = {1'b0, signal} >= limit;
   assign prio_bad = (priority_req == '0) || ({1'b0, priority_req} > MAX_PRIO);

   // Classify the item; range checks become a plain reply
   always_comb begin
      cmd.signal = signal;
      cmd.prio   = priority_req;
      cmd.status = ST_OK;
      cmd.op     = OP_REPLY;
      case (mode)
         MODE_PUBLISH: begin
            if (sig_over) begin
               cmd.status = ST_BADSIG;
            end else begin
               cmd.op = OP_PUBLISH;
            end
         end
         MODE_UNSUB_ALL: begin
            if (prio_bad) begin
               cmd.status = ST_BADPRIO;
            end else begin
               cmd.op = OP_CLEAR_ALL;
            end
         end
         default: begin
            if (prio_bad) begin
               cmd.status = ST_BADPRIO;
            end else if (sig_over || (signal < FIRST_SIG)) begin
               cmd.status = ST_BADSIG;
            end else if (mode == MODE_SUBSCRIBE) begin
               cmd.op = OP_SET;
            end else begin
               cmd.op = OP_CLEAR;
            end
         end
      endcase
   end

endmodule

// File: rtl/psr_queue.sv
`timescale 1ns / 1ps

module psr_queue
   import psr_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  cmd_type push_data,
   input  logic    pop,
   output cmd_type head,
   output logic    full,
   output logic    empty
);

   localparam int PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
   localparam int CNT_W = $clog2(Q_DEPTH + 1);
   localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(Q_DEPTH);
   localparam logic [PTR_W-1:0] LAST_PTR  = PTR_W'(Q_DEPTH - 1);

   cmd_type           slot_ff [Q_DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]  count_ff, count_in;

   assign full  = count_ff == DEPTH_CNT;
   assign empty = count_ff == '0;
   assign head  = slot_ff[rd_ptr_ff];

   // Pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Storage
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// File: rtl/psr_back.sv
`timescale 1ns / 1ps

module psr_back
   import psr_pkg::*;
#(
   parameter int MAX_ACTIVE        = DEF_MAX_ACTIVE,
   parameter int MAX_SIGNALS       = DEF_MAX_SIGNALS,
   parameter int FIRST_USER_SIGNAL = DEF_FIRST_USER_SIGNAL
) (
   input  logic               clock,
   input  logic               reset,
   input  logic [LIMIT_W-1:0] limit,
   input  cmd_type            head,
   input  logic               empty,
   output logic               pop,
   output logic [PRIO_W-1:0]  subscriber,
   output logic               last,
   output logic [STAT_W-1:0]  status,
   output logic               rsp_valid,
   input  logic               rsp_ready
);

   // Only rows a signal field can name are stored
   localparam int ROWS  = (MAX_SIGNALS < (1 << SIG_W)) ? MAX_SIGNALS : (1 << SIG_W);
   localparam int ROW_W = $clog2(ROWS);
   localparam int IDX_W = PRIO_W + 1;
   localparam logic [LIMIT_W-1:0] FIRST_ROW = LIMIT_W'(FIRST_USER_SIGNAL);

   typedef enum logic [2:0] {
      S_IDLE,
      S_PUB_WAIT,
      S_SCAN,
      S_RMW,
      S_SWEEP,
      S_EMIT
   } state_type;

   state_type              state_ff;
   cmd_type                cmd_ff;
   logic [MAX_ACTIVE-1:0]  bits_ff;
   logic [LIMIT_W-1:0]     row_ff;
   logic [STAT_W-1:0]      pend_ff;
   logic                   rsp_valid_ff;
   logic [PRIO_W-1:0]      sub_ff;
   logic                   last_ff;
   logic [STAT_W-1:0]      status_ff;

   // Subscriber table and its per-row valid bits
   logic [MAX_ACTIVE-1:0]  mem [ROWS];
   logic [ROWS-1:0]        valid_ff;
   logic [MAX_ACTIVE-1:0]  rd_data_ff;
   logic                   rd_valid_ff;

   logic                   mem_we;
   logic [ROW_W-1:0]       mem_wa;
   logic [MAX_ACTIVE-1:0]  mem_wd;
   logic [ROW_W-1:0]       mem_ra;

   logic [MAX_ACTIVE-1:0]  row_data;
   logic [MAX_ACTIVE-1:0]  prio_mask;
   logic [IDX_W-1:0]       hi_idx;
   logic [MAX_ACTIVE-1:0]  bits_left;
   logic [IDX_W-1:0]       hi_prio;
   logic [LIMIT_W-1:0]     row_next;
   logic                   slot_free;

   assign row_data  = rd_valid_ff ? rd_data_ff : '0;
   assign prio_mask = MAX_ACTIVE'(1) << (cmd_ff.prio - 1'b1);
   assign row_next  = row_ff + 1'b1;
   assign slot_free = !rsp_valid_ff || rsp_ready;
   assign pop       = (state_ff == S_IDLE) && !empty;

   // Highest subscribed priority still pending
   always_comb begin
      hi_idx = '0;
      for (int i = 0; i < MAX_ACTIVE; i++) begin
         if (bits_ff[i]) begin
            hi_idx = IDX_W'(i);
         end
      end
   end

   assign bits_left = bits_ff & ~(MAX_ACTIVE'(1) << hi_idx);
   assign hi_prio   = hi_idx + 1'b1;

   // Table read and write addresses
   always_comb begin
      mem_we = 1'b0;
      mem_wa = cmd_ff.signal[ROW_W-1:0];
      mem_wd = row_data & ~prio_mask;
      mem_ra = head.signal[ROW_W-1:0];
      case (state_ff)
         S_IDLE: begin
            if (head.op == OP_CLEAR_ALL) begin
               mem_ra = FIRST_ROW[ROW_W-1:0];
            end
         end
         S_RMW: begin
            mem_we = 1'b1;
            if (cmd_ff.op == OP_SET) begin
               mem_wd = row_data | prio_mask;
            end
         end
         S_SWEEP: begin
            mem_we = 1'b1;
            mem_wa = row_ff[ROW_W-1:0];
            mem_ra = row_next[ROW_W-1:0];
         end
         default: begin
            mem_we = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_wa] <= mem_wd;
      end
      rd_data_ff <= mem[mem_ra];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         if (mem_we) begin
            valid_ff[mem_wa] <= 1'b1;
         end
         rd_valid_ff <= valid_ff[mem_ra];
      end
   end

   // Sequencer and response register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            S_IDLE: begin
               if (!empty) begin
                  cmd_ff  <= head;
                  pend_ff <= head.status;
                  row_ff  <= FIRST_ROW;
                  case (head.op)
                     OP_PUBLISH: state_ff <= S_PUB_WAIT;
                     OP_SET,
                     OP_CLEAR: state_ff <= S_RMW;
                     OP_CLEAR_ALL: begin
                        pend_ff  <= ST_OK;
                        state_ff <= (FIRST_ROW >= limit) ? S_EMIT : S_SWEEP;
                     end
                     default: state_ff <= S_EMIT;
                  endcase
               end
            end
            S_PUB_WAIT: begin
               bits_ff <= row_data;
               if (row_data == '0) begin
                  pend_ff  <= ST_NONE;
                  state_ff <= S_EMIT;
               end else begin
                  state_ff <= S_SCAN;
               end
            end
            S_SCAN: begin
               if (slot_free) begin
                  rsp_valid_ff <= 1'b1;
                  sub_ff       <= hi_prio[PRIO_W-1:0];
                  last_ff      <= bits_left == '0;
                  status_ff    <= ST_OK;
                  bits_ff      <= bits_left;
                  if (bits_left == '0) begin
                     state_ff <= S_IDLE;
                  end
               end
            end
            S_RMW: begin
               pend_ff  <= ST_OK;
               state_ff <= S_EMIT;
            end
            S_SWEEP: begin
               row_ff <= row_next;
               if (row_next >= limit) begin
                  state_ff <= S_EMIT;
               end
            end
            S_EMIT: begin
               if (slot_free) begin
                  rsp_valid_ff <= 1'b1;
                  sub_ff       <= '0;
                  last_ff      <= 1'b1;
                  status_ff    <= pend_ff;
                  state_ff     <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign rsp_valid  = rsp_valid_ff;
   assign subscriber = sub_ff;
   assign last       = last_ff;
   assign status     = status_ff;

endmodule

// File: rtl/publish_subscribe_router.sv
`timescale 1ns / 1ps

// Publish/subscribe router: one subscriber bitmap per signal, bit p-1 for
// priority p. The front end checks and classifies each request and parks
// it in a two-entry command queue, so requests keep arriving while the
// back end works. The back end is a sequencer over a one-read, one-write
// table memory with registered read data. Per item: error reply; subscribe
// and unsubscribe read, write, acknowledge; publish gives one result per
// subscriber (status none when there are none), one result per cycle from
// the scan of the bitmap while the response channel is ready, highest
// priority first; unsubscribe-all walks rows FIRST_USER_SIGNAL up to the
// limit, one row per cycle, then acknowledges. The table clears at reset
// through per-row valid bits, with no clearing pass. The user must write
// the signal limit register only while the block is idle (not enforced).
module publish_subscribe_router
   import psr_pkg::*;
#(
   parameter int MAX_ACTIVE        = DEF_MAX_ACTIVE,
   parameter int MAX_SIGNALS       = DEF_MAX_SIGNALS,
   parameter int FIRST_USER_SIGNAL = DEF_FIRST_USER_SIGNAL
) (
   input  logic               clock,
   input  logic               reset,
   // request channel
   input  logic               req_tvalid,
   output logic               req_tready,
   input  logic [15:0]        req_tdata,   // signal[7:0], priority_req[13:8], zero[15:14]
   input  logic [MODE_W-1:0]  req_tuser,   // mode[1:0]
   // response channel
   output logic               rsp_tvalid,
   input  logic               rsp_tready,
   output logic [7:0]         rsp_tdata,   // subscriber[5:0], status[7:6]
   output logic               rsp_tlast,
   // configuration
   input  logic               csr_we,
   input  logic [LIMIT_W-1:0] csr_wdata
);

   logic [LIMIT_W-1:0] max_signal_ff;
   logic [LIMIT_W-1:0] limit;
   cmd_type            front_cmd;
   cmd_type            q_head;
   logic               q_full;
   logic               q_empty;
   logic               q_pop;
   logic               req_take;
   logic [PRIO_W-1:0]  subscriber;
   logic [STAT_W-1:0]  status;

   // Signal limit register
   always_ff @(posedge clock) begin
      if (reset) begin
         max_signal_ff <= MAX_SIGNAL_RESET;
      end else if (csr_we) begin
         max_signal_ff <= csr_wdata;
      end
   end

   // Effective limit is the smaller of the register and the table size
   assign limit = ({23'd0, max_signal_ff} < MAX_SIGNALS) ? max_signal_ff
                                                          : LIMIT_W'(MAX_SIGNALS);

   assign req_tready = !q_full;
   assign req_take   = req_tvalid && !q_full;

   psr_front #(
      .MAX_ACTIVE        (MAX_ACTIVE),
      .FIRST_USER_SIGNAL (FIRST_USER_SIGNAL)
   ) u_front (
      .mode         (req_tuser),
      .signal       (req_tdata[7:0]),
      .priority_req (req_tdata[13:8]),
      .limit        (limit),
      .cmd          (front_cmd)
   );

   psr_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (req_take),
      .push_data (front_cmd),
      .pop       (q_pop),
      .head      (q_head),
      .full      (q_full),
      .empty     (q_empty)
   );

   psr_back #(
      .MAX_ACTIVE        (MAX_ACTIVE),
      .MAX_SIGNALS       (MAX_SIGNALS),
      .FIRST_USER_SIGNAL (FIRST_USER_SIGNAL)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .limit      (limit),
      .head       (q_head),
      .empty      (q_empty),
      .pop        (q_pop),
      .subscriber (subscriber),
      .last       (rsp_tlast),
      .status     (status),
      .rsp_valid  (rsp_tvalid),
      .rsp_ready  (rsp_tready)
   );

   assign rsp_tdata = {status, subscriber};

endmodule

// File: verif/tb.sv
`timescale 1ns / 1ps

module tb;
   import psr_pkg::*;

   localparam int NUM_PRIO   = DEF_MAX_ACTIVE;
   localparam int NUM_SIG    = DEF_MAX_SIGNALS;
   localparam int FIRST_USER = DEF_FIRST_USER_SIGNAL;

   typedef struct {
      logic [MODE_W-1:0] mode;
      logic [SIG_W-1:0]  sig;
      logic [PRIO_W-1:0] prio;
   } req_item_type;

   typedef struct {
      logic [PRIO_W-1:0] subscriber;
      logic              last;
      logic [STAT_W-1:0] status;
   } rsp_item_type;

   // DUT connections, all inputs known from time zero
   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_tvalid = 1'b0;
   logic               req_tready;
   logic [15:0]        req_tdata = '0;   // signal[7:0], priority_req[13:8], zero[15:14]
   logic [MODE_W-1:0]  req_tuser = '0;   // mode[1:0]
   logic               rsp_tvalid;
   logic               rsp_tready = 1'b0;
   logic [7:0]         rsp_tdata;        // subscriber[5:0], status[7:6]
   logic               rsp_tlast;
   logic               csr_we = 1'b0;
   logic [LIMIT_W-1:0] csr_wdata = '0;

   // Predictor state: own copy of the bitmaps and the signal limit
   logic [NUM_PRIO-1:0] sub_map [NUM_SIG];
   logic [LIMIT_W-1:0]  max_sig_reg = MAX_SIGNAL_RESET;

   req_item_type pending_req [$];
   rsp_item_type expected_rsp [$];
   req_item_type drv_item;

   int  items_queued = 0;
   int  items_sent = 0;
   int  rsp_seen = 0;
   int  fanout_pubs = 0;
   int  limits_used = 0;
   int  errors = 0;
   int  gap_left = 0;
   int  stall_left = 0;
   bit  no_idle = 1'b0;

   publish_subscribe_router dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   initial begin
      foreach (sub_map[i]) sub_map[i] = '0;
   end

   // Mostly short gaps, now and then a long one
   function automatic int pick_gap(bit quiet);
      int r;
      r = $urandom_range(0, 99);
      if (quiet || r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   // Work out the responses one accepted item causes
   function automatic void route_request(logic [MODE_W-1:0] mode, logic [SIG_W-1:0] sig,
                                         logic [PRIO_W-1:0] prio);
      int lim;
      int n;
      rsp_item_type r;
      logic [NUM_PRIO-1:0] bits;
      lim = (max_sig_reg < NUM_SIG) ? int'(max_sig_reg) : NUM_SIG;
      r.subscriber = '0;
      r.last = 1'b1;
      r.status = ST_OK;
      if (mode == MODE_PUBLISH) begin
         if (int'(sig) >= lim) begin
            r.status = ST_BADSIG;
         end else if (sub_map[sig] == '0) begin
            r.status = ST_NONE;
         end else begin
            // one response per subscriber, highest priority first
            bits = sub_map[sig];
            n = 0;
            for (int p = NUM_PRIO; p >= 1; p--) begin
               if (bits[p-1]) begin
                  bits[p-1] = 1'b0;
                  r.subscriber = PRIO_W'(p);
                  r.last = (bits == '0);
                  expected_rsp.push_back(r);
                  n++;
               end
            end
            if (n > 1) fanout_pubs++;
            return;
         end
      end else if (prio == 0 || prio > NUM_PRIO) begin
         r.status = ST_BADPRIO;
      end else if (mode == MODE_UNSUB_ALL) begin
         for (int s = FIRST_USER; s < lim; s++) sub_map[s][prio-1] = 1'b0;
      end else if (int'(sig) < FIRST_USER || int'(sig) >= lim) begin
         r.status = ST_BADSIG;
      end else if (mode == MODE_SUBSCRIBE) begin
         sub_map[sig][prio-1] = 1'b1;
      end else begin
         sub_map[sig][prio-1] = 1'b0;
      end
      expected_rsp.push_back(r);
   endfunction

   // Request driver
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         gap_left = 0;
      end else begin
         if (req_tvalid && req_tready) begin
            route_request(req_tuser, req_tdata[7:0], req_tdata[13:8]);
            items_sent++;
         end
         if (!req_tvalid || req_tready) begin
            if (gap_left > 0) begin
               gap_left--;
               req_tvalid <= 1'b0;
            end else if (pending_req.size() > 0) begin
               drv_item = pending_req.pop_front();
               req_tvalid <= 1'b1;
               req_tuser <= drv_item.mode;
               req_tdata <= {2'b00, drv_item.prio, drv_item.sig};
               gap_left = pick_gap(no_idle);
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // Response monitor with random back-pressure
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         stall_left = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            rsp_seen++;
            if (expected_rsp.size() == 0) begin
               errors++;
               $display("%0t: unexpected item subscriber=%0d last=%0d status=%0d", $time,
                        rsp_tdata[5:0], rsp_tlast, rsp_tdata[7:6]);
            end else begin
               rsp_item_type e;
               e = expected_rsp.pop_front();
               if (rsp_tdata[5:0] !== e.subscriber) begin
                  errors++;
                  $display("%0t: subscriber mismatch expected %0d actual %0d", $time,
                           e.subscriber, rsp_tdata[5:0]);
               end
               if (rsp_tlast !== e.last) begin
                  errors++;
                  $display("%0t: last mismatch expected %0d actual %0d", $time,
                           e.last, rsp_tlast);
               end
               if (rsp_tdata[7:6] !== e.status) begin
                  errors++;
                  $display("%0t: status mismatch expected %0d actual %0d", $time,
                           e.status, rsp_tdata[7:6]);
               end
            end
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
            stall_left = pick_gap(no_idle);
         end
      end
   end

   task automatic add_item(logic [MODE_W-1:0] mode, int sig, int prio);
      req_item_type it;
      it.mode = mode;
      it.sig = sig[SIG_W-1:0];
      it.prio = prio[PRIO_W-1:0];
      pending_req.push_back(it);
      items_queued++;
   endtask

   // A signal inside the user range, mostly from a small pool near the bottom
   function automatic int pick_user_sig(int lim);
      int top;
      if (lim <= FIRST_USER) return $urandom_range(0, NUM_SIG - 1);
      top = (lim - 1 < FIRST_USER + 7) ? lim - 1 : FIRST_USER + 7;
      if ($urandom_range(0, 9) < 7) return $urandom_range(FIRST_USER, top);
      return $urandom_range(FIRST_USER, lim - 1);
   endfunction

   task automatic add_random(int count);
      int lim;
      int done;
      int r;
      int s;
      int k;
      lim = (max_sig_reg < NUM_SIG) ? int'(max_sig_reg) : NUM_SIG;
      done = 0;
      while (done < count) begin
         r = $urandom_range(0, 99);
         s = pick_user_sig(lim);
         if (r < 35) begin
            // subscribe a few priorities, then publish the signal
            k = $urandom_range(1, 6);
            repeat (k) add_item(MODE_SUBSCRIBE, s, $urandom_range(1, NUM_PRIO));
            add_item(MODE_PUBLISH, s, $urandom_range(0, 63));
            done += k + 1;
         end else begin
            if (r < 50)
               add_item(MODE_UNSUB, s, $urandom_range(1, NUM_PRIO));
            else if (r < 65)
               add_item(MODE_PUBLISH, s, $urandom_range(0, 63));
            else if (r < 70)
               add_item(MODE_UNSUB_ALL, $urandom_range(0, 255), $urandom_range(1, NUM_PRIO));
            else if (r < 75)
               add_item(MODE_PUBLISH, $urandom_range(0, 255), $urandom_range(0, 63));
            else
               add_item(MODE_W'($urandom_range(0, 3)), $urandom_range(0, 255),
                        $urandom_range(0, 63));
            done++;
         end
      end
   endtask

   task automatic wait_idle();
      do @(posedge clock);
      while (!(items_sent == items_queued && expected_rsp.size() == 0));
      repeat (20) @(posedge clock);
   endtask

   task automatic write_limit(logic [LIMIT_W-1:0] v);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_wdata <= v;
      @(posedge clock);
      csr_we <= 1'b0;
      max_sig_reg = v;
      limits_used++;
   endtask

   // Stimulus sequence
   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // directed checks at the reset limit
      add_item(MODE_PUBLISH, 0, 0);            // reserved signal, nobody there
      add_item(MODE_PUBLISH, 255, 63);         // top signal, empty, priority ignored
      add_item(MODE_SUBSCRIBE, 255, 32);
      add_item(MODE_SUBSCRIBE, 255, 1);
      add_item(MODE_SUBSCRIBE, 4, 17);
      add_item(MODE_SUBSCRIBE, 0, 5);          // reserved signal rejected
      add_item(MODE_SUBSCRIBE, 3, 1);
      add_item(MODE_SUBSCRIBE, 10, 0);         // priority zero
      add_item(MODE_SUBSCRIBE, 10, 33);        // priority above the top
      add_item(MODE_SUBSCRIBE, 2, 63);         // priority checked before signal
      add_item(MODE_PUBLISH, 255, 0);
      add_item(MODE_PUBLISH, 4, 42);
      add_item(MODE_UNSUB, 255, 32);
      add_item(MODE_PUBLISH, 255, 0);
      add_item(MODE_UNSUB, 4, 0);
      add_item(MODE_UNSUB, 1, 3);
      add_item(MODE_SUBSCRIBE, 128, 16);
      add_item(MODE_UNSUB_ALL, 7, 1);
      add_item(MODE_PUBLISH, 255, 0);
      add_item(MODE_UNSUB_ALL, 0, 0);
      add_item(MODE_UNSUB_ALL, 255, 40);
      add_item(MODE_PUBLISH, 128, 0);
      add_item(MODE_UNSUB_ALL, 200, 16);
      add_item(MODE_PUBLISH, 128, 0);
      wait_idle();

      // every priority on one signal, then a full fan-out
      for (int p = NUM_PRIO; p >= 1; p--) add_item(MODE_SUBSCRIBE, 9, p);
      add_item(MODE_PUBLISH, 9, 0);
      add_random(55);
      wait_idle();

      write_limit(9'd100);
      add_random(40);
      wait_idle();

      // limit at the first user signal: nothing can be subscribed
      write_limit(9'd4);
      add_item(MODE_UNSUB_ALL, 0, 9);
      add_item(MODE_PUBLISH, 3, 0);
      add_item(MODE_PUBLISH, 4, 0);
      add_random(20);
      wait_idle();

      write_limit(9'd0);
      add_random(8);
      wait_idle();

      // above the table size, rows left from before come back into reach
      no_idle = 1'b1;
      write_limit(9'd511);
      add_random(25);
      wait_idle();
      no_idle = 1'b0;
      add_random(25);
      wait_idle();

      write_limit(9'd37);
      add_random(30);
      wait_idle();

      write_limit(MAX_SIGNAL_RESET);
      add_item(MODE_PUBLISH, 9, 0);
      add_random(10);
      wait_idle();
      repeat (50) @(posedge clock);

      $display("Run covered %0d items and %0d responses, %0d publishes with several subscribers,",
               items_sent, rsp_seen, fanout_pubs);
      $display("under %0d signal limit writes besides the reset value.", limits_used);
      if (errors == 0 && expected_rsp.size() == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

   // Watchdog
   initial begin
      #15_000_000;
      $display("Timeout at %0t with %0d responses outstanding", $time, expected_rsp.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule

// File: files.f
rtl/psr_pkg.sv
rtl/psr_front.sv
rtl/psr_queue.sv
rtl/psr_back.sv
rtl/publish_subscribe_router.sv
verif/tb.sv
